@@ rtl/pdp11dec_pkg.sv @@
`timescale 1ns / 1ps
// pdp11dec_pkg: opcode table, format class codes, sys call argument counts
// and the decoded result type shared by the decoder, top level and checker
// depends on: nothing
package pdp11dec_pkg;

    // format class codes
    localparam logic [4:0] K_DBL  = 5'd0;
    localparam logic [4:0] K_SGL  = 5'd1;
    localparam logic [4:0] K_SGW  = 5'd2;
    localparam logic [4:0] K_MD   = 5'd3;
    localparam logic [4:0] K_BR   = 5'd4;
    localparam logic [4:0] K_NA   = 5'd5;
    localparam logic [4:0] K_FR   = 5'd6;
    localparam logic [4:0] K_FN   = 5'd7;
    localparam logic [4:0] K_JX   = 5'd8;
    localparam logic [4:0] K_RTS  = 5'd9;
    localparam logic [4:0] K_CC   = 5'd10;
    localparam logic [4:0] K_EMT  = 5'd11;
    localparam logic [4:0] K_SYS  = 5'd12;
    localparam logic [4:0] K_MARK = 5'd13;
    localparam logic [4:0] K_SOB  = 5'd14;
    localparam logic [4:0] K_SPL  = 5'd15;
    localparam logic [4:0] K_UNK  = 5'd16;

    localparam int         N_ENTRIES = 87;
    // subtract shares bit 15 with the byte forms but is a word operation
    localparam logic [6:0] IDX_SUB   = 7'd6;
    localparam logic [6:0] IDX_UNK   = 7'd86;

    typedef struct packed {
        logic [15:0] mask;
        logic [15:0] val;
        logic [4:0]  kind;
    } op_entry_t;

    // masked compare table, first match wins, last entry matches everything
    localparam op_entry_t OP_TABLE [0:N_ENTRIES-1] = '{
        '{16'o107777, 16'o010000, K_DBL}, '{16'o107777, 16'o020000, K_DBL},
        '{16'o107777, 16'o030000, K_DBL}, '{16'o107777, 16'o040000, K_DBL},
        '{16'o107777, 16'o050000, K_DBL}, '{16'o007777, 16'o060000, K_DBL},
        '{16'o007777, 16'o160000, K_DBL},
        '{16'o100077, 16'o005000, K_SGL}, '{16'o100077, 16'o005100, K_SGL},
        '{16'o100077, 16'o005200, K_SGL}, '{16'o100077, 16'o005300, K_SGL},
        '{16'o100077, 16'o005400, K_SGL}, '{16'o100077, 16'o005500, K_SGL},
        '{16'o100077, 16'o005600, K_SGL}, '{16'o100077, 16'o005700, K_SGL},
        '{16'o100077, 16'o006000, K_SGL}, '{16'o100077, 16'o006100, K_SGL},
        '{16'o100077, 16'o006200, K_SGL}, '{16'o100077, 16'o006300, K_SGL},
        '{16'o000077, 16'o000100, K_SGL}, '{16'o000077, 16'o000300, K_SGL},
        '{16'o000077, 16'o170100, K_SGW}, '{16'o000077, 16'o170200, K_SGW},
        '{16'o000077, 16'o170300, K_SGW}, '{16'o000077, 16'o170400, K_SGW},
        '{16'o000077, 16'o170500, K_SGW}, '{16'o000077, 16'o170600, K_SGW},
        '{16'o000077, 16'o170700, K_SGW}, '{16'o000077, 16'o006700, K_SGW},
        '{16'o000077, 16'o006600, K_SGW}, '{16'o000077, 16'o106600, K_SGW},
        '{16'o000077, 16'o006500, K_SGW}, '{16'o000077, 16'o106500, K_SGW},
        '{16'o000777, 16'o070000, K_MD},  '{16'o000777, 16'o071000, K_MD},
        '{16'o000777, 16'o072000, K_MD},  '{16'o000777, 16'o073000, K_MD},
        '{16'o000377, 16'o000400, K_BR},  '{16'o000377, 16'o001000, K_BR},
        '{16'o000377, 16'o001400, K_BR},  '{16'o000377, 16'o002000, K_BR},
        '{16'o000377, 16'o002400, K_BR},  '{16'o000377, 16'o003000, K_BR},
        '{16'o000377, 16'o003400, K_BR},  '{16'o000377, 16'o100000, K_BR},
        '{16'o000377, 16'o100400, K_BR},  '{16'o000377, 16'o101000, K_BR},
        '{16'o000377, 16'o101400, K_BR},  '{16'o000377, 16'o102000, K_BR},
        '{16'o000377, 16'o102400, K_BR},  '{16'o000377, 16'o103000, K_BR},
        '{16'o000377, 16'o103400, K_BR},
        '{16'o000000, 16'o000000, K_NA},  '{16'o000000, 16'o000001, K_NA},
        '{16'o000000, 16'o000002, K_NA},  '{16'o000000, 16'o000004, K_NA},
        '{16'o000000, 16'o000005, K_NA},
        '{16'o000377, 16'o171000, K_FR},  '{16'o000377, 16'o171400, K_FR},
        '{16'o000377, 16'o172000, K_FR},  '{16'o000377, 16'o172400, K_FR},
        '{16'o000377, 16'o173000, K_FR},  '{16'o000377, 16'o173400, K_FR},
        '{16'o000377, 16'o174000, K_FN},  '{16'o000377, 16'o174400, K_FR},
        '{16'o000377, 16'o175000, K_FN},  '{16'o000377, 16'o175400, K_FN},
        '{16'o000377, 16'o176000, K_FN},  '{16'o000377, 16'o176400, K_FR},
        '{16'o000377, 16'o177000, K_FR},  '{16'o000377, 16'o177400, K_FR},
        '{16'o000000, 16'o170000, K_NA},  '{16'o000000, 16'o170001, K_NA},
        '{16'o000000, 16'o170002, K_NA},  '{16'o000000, 16'o170011, K_NA},
        '{16'o000000, 16'o170012, K_NA},
        '{16'o000777, 16'o004000, K_JX},  '{16'o000777, 16'o074000, K_JX},
        '{16'o000007, 16'o000200, K_RTS},
        '{16'o000017, 16'o000240, K_CC},  '{16'o000017, 16'o000260, K_CC},
        '{16'o000377, 16'o104000, K_EMT}, '{16'o000377, 16'o104400, K_SYS},
        '{16'o000077, 16'o006400, K_MARK}, '{16'o000777, 16'o077000, K_SOB},
        '{16'o000007, 16'o000230, K_SPL},
        '{16'o177777, 16'o000000, K_UNK}
    };

    // argument words following each sys call, by call number
    localparam logic [2:0] SYS_ARGC [0:63] = '{
        3'd1, 3'd0, 3'd0, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0,
        3'd2, 3'd2, 3'd1, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2,
        3'd2, 3'd1, 3'd2, 3'd2, 3'd0, 3'd3, 3'd1, 3'd0,
        3'd0, 3'd0, 3'd3, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1,
        3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd1, 3'd4, 3'd0, 3'd0, 3'd0,
        3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
    };

    typedef struct packed {
        logic [6:0]  mnemonic_index;
        logic [4:0]  format_class;
        logic        byte_op;
        logic [5:0]  src_spec;
        logic [5:0]  dst_spec;
        logic [7:0]  literal;
        logic [15:0] branch_target;
        logic [15:0] src_value;
        logic [15:0] dst_value;
        logic [2:0]  length_words;
    } dec_result_t;

endpackage

@@ rtl/pdp11dec_decode.sv @@
`timescale 1ns / 1ps
// pdp11dec_decode: single pass combinational decode of one instruction
// depends on: pdp11dec_pkg (opcode table, class codes, result type)
module pdp11dec_decode import pdp11dec_pkg::*; (
    input  logic [15:0]  instr_word,
    input  logic [15:0]  instr_addr,
    input  logic [15:0]  ext_first,
    input  logic [15:0]  ext_second,
    output dec_result_t  result
);

    logic [6:0]  idx;
    logic [4:0]  kind;
    logic        byte_op;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [7:0]  lit;
    logic [15:0] target;
    logic        src_resolve;
    logic        dst_resolve;
    logic        src_ext;
    logic        dst_ext;
    logic [15:0] dst_word;
    logic [15:0] dst_pc_base;
    logic [15:0] src_val;
    logic [15:0] dst_val;
    logic [2:0]  words;

    // operand takes an extension word: pc immediate/absolute/relative or indexed
    function automatic logic needs_ext(input logic [5:0] spec);
        needs_ext = ((spec[2:0] == 3'd7) && spec[4]) || (spec[5:4] == 2'b11);
    endfunction

    // pc relative forms add the address of the following word
    function automatic logic pc_rel(input logic [5:0] spec);
        pc_rel = (spec[2:0] == 3'd7) && spec[5];
    endfunction

    // priority match, scanned from the end so the lowest index wins
    always_comb begin
        idx = IDX_UNK;
        for (int i = N_ENTRIES - 1; i >= 0; i--) begin
            if ((instr_word & ~OP_TABLE[i].mask) == OP_TABLE[i].val) begin
                idx = 7'(i);
            end
        end
    end

    assign kind = OP_TABLE[idx].kind;

    // field extraction per format class
    always_comb begin
        byte_op = 1'b0;
        src     = 6'd0;
        dst     = 6'd0;
        lit     = 8'd0;
        target  = 16'd0;
        case (kind)
            K_DBL: begin
                byte_op = (idx != IDX_SUB) ? instr_word[15] : 1'b0;
                src     = instr_word[11:6];
                dst     = instr_word[5:0];
            end
            K_SGL: begin
                byte_op = instr_word[15];
                dst     = instr_word[5:0];
            end
            K_SGW: dst = instr_word[5:0];
            K_MD: begin
                src = instr_word[5:0];
                dst = {3'd0, instr_word[8:6]};
            end
            K_FR: begin
                src = instr_word[5:0];
                dst = {4'd0, instr_word[7:6]};
            end
            K_FN: begin
                src = {4'd0, instr_word[7:6]};
                dst = instr_word[5:0];
            end
            K_JX: begin
                src = {3'd0, instr_word[8:6]};
                dst = instr_word[5:0];
            end
            K_RTS: dst = {3'd0, instr_word[2:0]};
            K_BR: begin
                target = instr_addr + {{7{instr_word[7]}}, instr_word[7:0], 1'b0}
                         + 16'd2;
            end
            K_SOB: begin
                src    = {3'd0, instr_word[8:6]};
                target = instr_addr + 16'd2 - {9'd0, instr_word[5:0], 1'b0};
            end
            K_CC:   lit = {4'd0, instr_word[3:0]};
            K_EMT:  lit = instr_word[7:0];
            K_SYS:  lit = {2'd0, instr_word[5:0]};
            K_MARK: lit = {2'd0, instr_word[5:0]};
            K_SPL:  lit = {5'd0, instr_word[2:0]};
            default: begin
            end
        endcase
    end

    // which classes carry general operands that may resolve
    assign src_resolve = (kind == K_DBL) || (kind == K_MD) || (kind == K_FR) ||
                         (kind == K_FN) || (kind == K_JX);
    assign dst_resolve = src_resolve || (kind == K_SGL) || (kind == K_SGW);
    assign src_ext     = src_resolve && needs_ext(src);
    assign dst_ext     = dst_resolve && needs_ext(dst);

    // source always takes the first extension word
    assign src_val = !src_ext     ? 16'd0 :
                     pc_rel(src)  ? ext_first + instr_addr + 16'd4 : ext_first;

    // destination takes the next unused extension word
    assign dst_word    = src_ext ? ext_second : ext_first;
    assign dst_pc_base = src_ext ? instr_addr + 16'd6 : instr_addr + 16'd4;
    assign dst_val     = !dst_ext    ? 16'd0 :
                         pc_rel(dst) ? dst_word + dst_pc_base : dst_word;

    // length in words, sys calls count their argument words
    always_comb begin
        if (kind == K_SYS) begin
            words = 3'd1 + SYS_ARGC[instr_word[5:0]];
        end else begin
            words = 3'd1 + {2'd0, src_ext} + {2'd0, dst_ext};
        end
    end

    assign result.mnemonic_index = idx;
    assign result.format_class   = kind;
    assign result.byte_op        = byte_op;
    assign result.src_spec       = src;
    assign result.dst_spec       = dst;
    assign result.literal        = lit;
    assign result.branch_target  = target;
    assign result.src_value      = src_val;
    assign result.dst_value      = dst_val;
    assign result.length_words   = words;

endmodule

@@ rtl/pdp11_instruction_decoder_core.sv @@
`timescale 1ns / 1ps
// pdp11_instruction_decoder_core: input register, decode, result register
// the request is held in the input reg, decoded, then held in the result reg
// throughput: one request per cycle when not stalled, set by the single pass decode
// both stages advance together when the result is taken; a stalled result holds
// reset (aresetn low, synchronous) empties both stages; payload regs are not reset
// depends on: pdp11dec_pkg, pdp11dec_decode
module pdp11_instruction_decoder_core import pdp11dec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instr_word,
    input  logic [15:0] s_instr_addr,
    input  logic [15:0] s_ext_first,
    input  logic [15:0] s_ext_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_mnemonic_index,
    output logic [4:0]  m_format_class,
    output logic        m_byte_op,
    output logic [5:0]  m_src_spec,
    output logic [5:0]  m_dst_spec,
    output logic [7:0]  m_literal,
    output logic [15:0] m_branch_target,
    output logic [15:0] m_src_value,
    output logic [15:0] m_dst_value,
    output logic [2:0]  m_length_words
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] word_reg;
    logic [15:0] addr_reg;
    logic [15:0] ext1_reg;
    logic [15:0] ext2_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t res_reg;
    dec_result_t dec_res;
    logic        advance;

    // result stage moves when empty or taken; input stage when it can empty
    assign advance        = !out_valid_reg || m_ready;
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // handshake state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_instr_word;
            addr_reg <= s_instr_addr;
            ext1_reg <= s_ext_first;
            ext2_reg <= s_ext_second;
        end
    end

    pdp11dec_decode u_decode (
        .instr_word (word_reg),
        .instr_addr (addr_reg),
        .ext_first  (ext1_reg),
        .ext_second (ext2_reg),
        .result     (dec_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            res_reg <= dec_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_mnemonic_index = res_reg.mnemonic_index;
    assign m_format_class   = res_reg.format_class;
    assign m_byte_op        = res_reg.byte_op;
    assign m_src_spec       = res_reg.src_spec;
    assign m_dst_spec       = res_reg.dst_spec;
    assign m_literal        = res_reg.literal;
    assign m_branch_target  = res_reg.branch_target;
    assign m_src_value      = res_reg.src_value;
    assign m_dst_value      = res_reg.dst_value;
    assign m_length_words   = res_reg.length_words;

endmodule

@@ rtl/pdp11dec_checker.sv @@
`timescale 1ns / 1ps
// pdp11dec_checker: port level checks on the decoder core, bound to the top level
// depends on: pdp11dec_pkg (class codes), pdp11_instruction_decoder_core
module pdp11dec_checker import pdp11dec_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [6:0]  m_mnemonic_index,
    input logic [4:0]  m_format_class,
    input logic        m_byte_op,
    input logic [7:0]  m_literal,
    input logic [2:0]  m_length_words
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mnemonic_index)
            && $stable(m_length_words) && $stable(m_literal))
        else $error("stalled result changed");

    // length stays within one to five words
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_length_words != 3'd0) && (m_length_words <= 3'd5))
        else $error("length out of range");

    // unknown word is one bare word with the last table index
    a_unknown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_format_class == K_UNK) |->
            (m_length_words == 3'd1) && (m_literal == 8'd0)
            && (m_mnemonic_index == IDX_UNK))
        else $error("unknown word decoded wrongly");

    // byte flag only on double and single operand classes
    a_byte_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_op |-> (m_format_class == K_DBL) || (m_format_class == K_SGL))
        else $error("byte flag on wrong class");

endmodule

bind pdp11_instruction_decoder_core pdp11dec_checker u_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mnemonic_index (m_mnemonic_index),
    .m_format_class   (m_format_class),
    .m_byte_op        (m_byte_op),
    .m_literal        (m_literal),
    .m_length_words   (m_length_words)
);

@@ tb/tb_pdp11_instruction_decoder_core.sv @@
`timescale 1ns / 1ps
// tb_pdp11_instruction_decoder_core: self-checking bench for the instruction decoder,
// with an independent opcode predictor, random idling on both channels and a long output hold
// depends on: pdp11dec_pkg (class codes, result type), pdp11_instruction_decoder_core
module tb_pdp11_instruction_decoder_core;
    import pdp11dec_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // one row of the opcode map: bits set in free_bits are ignored in the compare
    typedef struct packed {
        logic [15:0] free_bits;
        logic [15:0] pattern;
        logic [4:0]  fmt;
    } opcode_pattern_t;

    typedef struct packed {
        logic [15:0] word;
        dec_result_t result;
    } decode_check_t;

    localparam opcode_pattern_t DECODE_MAP [0:N_ENTRIES-1] = '{
        '{16'o107777, 16'o010000, K_DBL}, '{16'o107777, 16'o020000, K_DBL},
        '{16'o107777, 16'o030000, K_DBL}, '{16'o107777, 16'o040000, K_DBL},
        '{16'o107777, 16'o050000, K_DBL}, '{16'o007777, 16'o060000, K_DBL},
        '{16'o007777, 16'o160000, K_DBL},
        '{16'o100077, 16'o005000, K_SGL}, '{16'o100077, 16'o005100, K_SGL},
        '{16'o100077, 16'o005200, K_SGL}, '{16'o100077, 16'o005300, K_SGL},
        '{16'o100077, 16'o005400, K_SGL}, '{16'o100077, 16'o005500, K_SGL},
        '{16'o100077, 16'o005600, K_SGL}, '{16'o100077, 16'o005700, K_SGL},
        '{16'o100077, 16'o006000, K_SGL}, '{16'o100077, 16'o006100, K_SGL},
        '{16'o100077, 16'o006200, K_SGL}, '{16'o100077, 16'o006300, K_SGL},
        '{16'o000077, 16'o000100, K_SGL}, '{16'o000077, 16'o000300, K_SGL},
        '{16'o000077, 16'o170100, K_SGW}, '{16'o000077, 16'o170200, K_SGW},
        '{16'o000077, 16'o170300, K_SGW}, '{16'o000077, 16'o170400, K_SGW},
        '{16'o000077, 16'o170500, K_SGW}, '{16'o000077, 16'o170600, K_SGW},
        '{16'o000077, 16'o170700, K_SGW}, '{16'o000077, 16'o006700, K_SGW},
        '{16'o000077, 16'o006600, K_SGW}, '{16'o000077, 16'o106600, K_SGW},
        '{16'o000077, 16'o006500, K_SGW}, '{16'o000077, 16'o106500, K_SGW},
        '{16'o000777, 16'o070000, K_MD},  '{16'o000777, 16'o071000, K_MD},
        '{16'o000777, 16'o072000, K_MD},  '{16'o000777, 16'o073000, K_MD},
        '{16'o000377, 16'o000400, K_BR},  '{16'o000377, 16'o001000, K_BR},
        '{16'o000377, 16'o001400, K_BR},  '{16'o000377, 16'o002000, K_BR},
        '{16'o000377, 16'o002400, K_BR},  '{16'o000377, 16'o003000, K_BR},
        '{16'o000377, 16'o003400, K_BR},  '{16'o000377, 16'o100000, K_BR},
        '{16'o000377, 16'o100400, K_BR},  '{16'o000377, 16'o101000, K_BR},
        '{16'o000377, 16'o101400, K_BR},  '{16'o000377, 16'o102000, K_BR},
        '{16'o000377, 16'o102400, K_BR},  '{16'o000377, 16'o103000, K_BR},
        '{16'o000377, 16'o103400, K_BR},
        '{16'o000000, 16'o000000, K_NA},  '{16'o000000, 16'o000001, K_NA},
        '{16'o000000, 16'o000002, K_NA},  '{16'o000000, 16'o000004, K_NA},
        '{16'o000000, 16'o000005, K_NA},
        '{16'o000377, 16'o171000, K_FR},  '{16'o000377, 16'o171400, K_FR},
        '{16'o000377, 16'o172000, K_FR},  '{16'o000377, 16'o172400, K_FR},
        '{16'o000377, 16'o173000, K_FR},  '{16'o000377, 16'o173400, K_FR},
        '{16'o000377, 16'o174000, K_FN},  '{16'o000377, 16'o174400, K_FR},
        '{16'o000377, 16'o175000, K_FN},  '{16'o000377, 16'o175400, K_FN},
        '{16'o000377, 16'o176000, K_FN},  '{16'o000377, 16'o176400, K_FR},
        '{16'o000377, 16'o177000, K_FR},  '{16'o000377, 16'o177400, K_FR},
        '{16'o000000, 16'o170000, K_NA},  '{16'o000000, 16'o170001, K_NA},
        '{16'o000000, 16'o170002, K_NA},  '{16'o000000, 16'o170011, K_NA},
        '{16'o000000, 16'o170012, K_NA},
        '{16'o000777, 16'o004000, K_JX},  '{16'o000777, 16'o074000, K_JX},
        '{16'o000007, 16'o000200, K_RTS},
        '{16'o000017, 16'o000240, K_CC},  '{16'o000017, 16'o000260, K_CC},
        '{16'o000377, 16'o104000, K_EMT}, '{16'o000377, 16'o104400, K_SYS},
        '{16'o000077, 16'o006400, K_MARK}, '{16'o000777, 16'o077000, K_SOB},
        '{16'o000007, 16'o000230, K_SPL},
        '{16'o177777, 16'o000000, K_UNK}
    };

    // argument words that follow each system call, by call number
    localparam int SYSCALL_ARG_WORDS [0:63] = '{
        1, 0, 0, 2, 2, 2, 0, 0,  2, 2, 1, 2, 1, 0, 3, 2,
        2, 1, 2, 2, 0, 3, 1, 0,  0, 0, 3, 0, 1, 0, 1, 1,
        1, 0, 0, 0, 0, 1, 0, 0,  0, 0, 0, 1, 4, 0, 0, 0,
        2, 0, 0, 0, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0, 0
    };

    // hand-picked words: every class, pc and indexed operand kinds, corner offsets
    localparam logic [15:0] DIRECTED_WORDS [0:26] = '{
        16'o012727, 16'o113737, 16'o016767, 16'o166561, 16'o005067, 16'o105077,
        16'o006727, 16'o070527, 16'o000777, 16'o000577, 16'o100200, 16'o000000,
        16'o170011, 16'o172467, 16'o174367, 16'o004767, 16'o074027, 16'o000207,
        16'o000277, 16'o104377, 16'o104400, 16'o104454, 16'o006477, 16'o077177,
        16'o000237, 16'o000007, 16'o177777
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instr_word;
    logic [15:0] s_instr_addr;
    logic [15:0] s_ext_first;
    logic [15:0] s_ext_second;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_mnemonic_index;
    logic [4:0]  m_format_class;
    logic        m_byte_op;
    logic [5:0]  m_src_spec;
    logic [5:0]  m_dst_spec;
    logic [7:0]  m_literal;
    logic [15:0] m_branch_target;
    logic [15:0] m_src_value;
    logic [15:0] m_dst_value;
    logic [2:0]  m_length_words;

    decode_check_t pending_decodes [$];
    int unsigned   mismatches = 0;
    int unsigned   requests_sent = 0;
    int unsigned   results_checked = 0;
    int unsigned   input_stall_cycles = 0;
    int unsigned   idle_cycles = 0;
    logic [16:0]   classes_seen = '0;
    bit            gaps_on = 1'b1;
    bit            hold_request = 1'b0;
    int unsigned   hold_left = 0;
    int unsigned   stall_left = 0;

    pdp11_instruction_decoder_core dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_instr_word     (s_instr_word),
        .s_instr_addr     (s_instr_addr),
        .s_ext_first      (s_ext_first),
        .s_ext_second     (s_ext_second),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mnemonic_index (m_mnemonic_index),
        .m_format_class   (m_format_class),
        .m_byte_op        (m_byte_op),
        .m_src_spec       (m_src_spec),
        .m_dst_spec       (m_dst_spec),
        .m_literal        (m_literal),
        .m_branch_target  (m_branch_target),
        .m_src_value      (m_src_value),
        .m_dst_value      (m_dst_value),
        .m_length_words   (m_length_words)
    );

    always #6 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // operand needs an extension word: pc immediate/absolute/relative, or indexed
    function automatic bit takes_ext(input logic [5:0] spec);
        return (spec[2:0] == 3'd7 && spec[4]) || (spec[5:4] == 2'b11);
    endfunction

    // value of an operand from the extension word at the current position
    function automatic logic [15:0] operand_word(input logic [5:0] spec,
                                                 input logic [15:0] addr,
                                                 input logic [15:0] ext_a,
                                                 input logic [15:0] ext_b,
                                                 input int used);
        logic [15:0] ext;
        logic [15:0] adj;
        ext = (used <= 1) ? ext_a : ext_b;
        adj = 16'(2 * used + 2);
        // pc relative: offset from the address just past this extension word
        if (spec[2:0] == 3'd7 && spec[5]) return ext + addr + adj;
        return ext;
    endfunction

    // expected decode of one instruction
    function automatic dec_result_t predict_decode(input logic [15:0] word,
                                                   input logic [15:0] addr,
                                                   input logic [15:0] ext_a,
                                                   input logic [15:0] ext_b);
        dec_result_t r;
        int          hit;
        int          used;
        logic [4:0]  fmt;
        hit = int'(IDX_UNK);
        for (int i = N_ENTRIES - 1; i >= 0; i--) begin
            if ((word & ~DECODE_MAP[i].free_bits) == DECODE_MAP[i].pattern) hit = i;
        end
        fmt = DECODE_MAP[hit].fmt;
        r = '0;
        r.mnemonic_index = 7'(hit);
        r.format_class = fmt;
        used = 1;
        case (fmt)
            K_DBL: begin
                r.byte_op = (hit != IDX_SUB) && word[15];
                r.src_spec = word[11:6];
                r.dst_spec = word[5:0];
            end
            K_SGL: begin
                r.byte_op = word[15];
                r.dst_spec = word[5:0];
            end
            K_SGW: r.dst_spec = word[5:0];
            K_MD: begin
                r.src_spec = word[5:0];
                r.dst_spec = {3'b000, word[8:6]};
            end
            K_FR: begin
                r.src_spec = word[5:0];
                r.dst_spec = {4'b0000, word[7:6]};
            end
            K_FN: begin
                r.src_spec = {4'b0000, word[7:6]};
                r.dst_spec = word[5:0];
            end
            K_JX: begin
                r.src_spec = {3'b000, word[8:6]};
                r.dst_spec = word[5:0];
            end
            K_RTS: r.dst_spec = {3'b000, word[2:0]};
            K_BR: r.branch_target = addr + 16'd2 + {{7{word[7]}}, word[7:0], 1'b0};
            K_SOB: begin
                r.src_spec = {3'b000, word[8:6]};
                r.branch_target = addr + 16'd2 - {9'b0, word[5:0], 1'b0};
            end
            K_CC:   r.literal = {4'b0000, word[3:0]};
            K_EMT:  r.literal = word[7:0];
            K_SYS: begin
                r.literal = {2'b00, word[5:0]};
                used = used + SYSCALL_ARG_WORDS[word[5:0]];
            end
            K_MARK: r.literal = {2'b00, word[5:0]};
            K_SPL:  r.literal = {5'b00000, word[2:0]};
            default: ;
        endcase
        // source operand takes the first extension word
        if (fmt == K_DBL || fmt == K_MD || fmt == K_FR || fmt == K_FN || fmt == K_JX) begin
            if (takes_ext(r.src_spec)) begin
                r.src_value = operand_word(r.src_spec, addr, ext_a, ext_b, used);
                used++;
            end
        end
        if (fmt == K_DBL || fmt == K_SGL || fmt == K_SGW || fmt == K_MD ||
            fmt == K_FR || fmt == K_FN || fmt == K_JX) begin
            if (takes_ext(r.dst_spec)) begin
                r.dst_value = operand_word(r.dst_spec, addr, ext_a, ext_b, used);
                used++;
            end
        end
        r.length_words = 3'(used);
        return r;
    endfunction

    // offer one request, hold it until taken, then log its expected decode
    task automatic send_request(input logic [15:0] word, input logic [15:0] addr,
                                input logic [15:0] ext_a, input logic [15:0] ext_b);
        int unsigned   gap;
        decode_check_t entry;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_instr_word <= word;
        s_instr_addr <= addr;
        s_ext_first  <= ext_a;
        s_ext_second <= ext_b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        entry.word = word;
        entry.result = predict_decode(word, addr, ext_a, ext_b);
        pending_decodes.push_back(entry);
        classes_seen[entry.result.format_class] = 1'b1;
        requests_sent++;
    endtask

    // word mostly from a random map row with random don't-care bits, biased towards pc operands
    function automatic logic [15:0] random_word();
        logic [15:0] word;
        int unsigned row;
        row = $urandom_range(0, N_ENTRIES - 1);
        if ($urandom_range(0, 9) < 7)
            word = DECODE_MAP[row].pattern | (16'($urandom) & DECODE_MAP[row].free_bits);
        else
            word = 16'($urandom);
        if ($urandom_range(0, 3) == 0) word[2:0] = 3'd7;
        if ($urandom_range(0, 4) == 0) word[8:6] = 3'd7;
        return word;
    endfunction

    task automatic send_random(input int unsigned count);
        logic [15:0] addr;
        for (int unsigned n = 0; n < count; n++) begin
            addr = 16'($urandom);
            // now and then near the top of memory so targets wrap
            if ($urandom_range(0, 7) == 0) addr[15:4] = 12'hfff;
            send_request(random_word(), addr, 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_directed_opcodes();
        logic [15:0] addr;
        logic [15:0] ext_a;
        logic [15:0] ext_b;
        for (int i = 0; i < 27; i++) begin
            addr  = (i % 4 == 3) ? 16'o177774 : 16'(16'o001000 + 4 * i);
            ext_a = 16'o001234 ^ 16'(i);
            ext_b = 16'o177000 | 16'(i);
            if (i == 11) begin
                addr = '0; ext_a = '0; ext_b = '0;
            end
            if (i == 26) begin
                addr = '1; ext_a = '1; ext_b = '1;
            end
            send_request(DIRECTED_WORDS[i], addr, ext_a, ext_b);
        end
    endtask

    // every map row twice, with random don't-care bits and operands
    task automatic test_every_map_row();
        logic [15:0] word;
        for (int pass = 0; pass < 2; pass++) begin
            for (int row = 0; row < N_ENTRIES; row++) begin
                word = DECODE_MAP[row].pattern | (16'($urandom) & DECODE_MAP[row].free_bits);
                send_request(word, 16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_random_stream();
        send_random(500);
    endtask

    // full rate on both sides
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        send_random(60);
        gaps_on = 1'b1;
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_hold();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        send_random(40);
        gaps_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] word,
                               input logic [15:0] exp, input logic [15:0] act);
        if (exp !== act) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s for word %06o: expected %0h, got %0h",
                         name, word, exp, act);
        end
    endtask

    // compare each result with the oldest outstanding decode
    always @(posedge aclk) begin : result_check
        decode_check_t exp;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_decodes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no request outstanding: index %0d class %0d",
                             m_mnemonic_index, m_format_class);
            end else begin
                exp = pending_decodes.pop_front();
                results_checked++;
                check_field("mnemonic_index", exp.word, 16'(exp.result.mnemonic_index),
                            16'(m_mnemonic_index));
                check_field("format_class", exp.word, 16'(exp.result.format_class),
                            16'(m_format_class));
                check_field("byte_op", exp.word, 16'(exp.result.byte_op), 16'(m_byte_op));
                check_field("src_spec", exp.word, 16'(exp.result.src_spec),
                            16'(m_src_spec));
                check_field("dst_spec", exp.word, 16'(exp.result.dst_spec),
                            16'(m_dst_spec));
                check_field("literal", exp.word, 16'(exp.result.literal), 16'(m_literal));
                check_field("branch_target", exp.word, exp.result.branch_target,
                            m_branch_target);
                check_field("src_value", exp.word, exp.result.src_value, m_src_value);
                check_field("dst_value", exp.word, exp.result.dst_value, m_dst_value);
                check_field("length_words", exp.word, 16'(exp.result.length_words),
                            16'(m_length_words));
            end
        end
    end

    // watchdog on handshake activity, plus input stall count
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid === 1'b1 && s_ready !== 1'b1) input_stall_cycles++;
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_decodes.size());
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles++;
            end
        end
    end

    // result side: random stalls, or one long hold when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0 && gaps_on) stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // reset, test sequence, drain and verdict
    initial begin
        int unsigned class_count;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_instr_word = '0;
        s_instr_addr = '0;
        s_ext_first  = '0;
        s_ext_second = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_opcodes();
        test_every_map_row();
        test_random_stream();
        test_back_to_back();
        test_output_hold();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_decodes.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        class_count = 0;
        for (int k = 0; k < 17; k++) class_count += classes_seen[k];
        $display("decoded %0d requests, checked %0d results, %0d of 17 format classes seen",
                 requests_sent, results_checked, class_count);
        $display("input held off %0d cycles by output back-pressure, %0d mismatches",
                 input_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
